[design/sorted_held_note_table_assert.svh]
// Assertion macros shared by the held-note table modules.
`ifndef SORTED_HELD_NOTE_TABLE_ASSERT_SVH
`define SORTED_HELD_NOTE_TABLE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SHNT_ASSERT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SHNT_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[design/shnt_pkg.sv]
// Types and constants for the sorted held-note table.
package shnt_pkg;

  localparam int MAX_OUT = 16;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_DUMP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_HELD   = 2'd1,
    STAT_ABSENT = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_SHR,
    ST_SHW,
    ST_EMIT
  } state_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] note;
    logic [7:0] velocity;
  } cmd_t;

  typedef struct packed {
    logic [7:0] note;
    logic [7:0] velocity;
    logic       entry_valid;
    status_t    status;
    logic       last;
    logic [4:0] held_count;
  } result_t;

endpackage

[design/shnt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module shnt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/shnt_core.sv]
// Sequencer and shared key comparator that walk and shift the note table.
module shnt_core #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  shnt_pkg::cmd_t    cmd,
  output logic              res_valid,
  input  logic              res_ready,
  output shnt_pkg::result_t res
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  shnt_pkg::state_t  state_r, state_nxt;
  shnt_pkg::mode_t   mode_r, mode_nxt;
  shnt_pkg::status_t status_r, status_nxt;
  logic [7:0]        note_r, note_nxt;
  logic [7:0]        vel_r, vel_nxt;
  logic              ent_r, ent_nxt;
  logic [CW-1:0]     ptr_r, ptr_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;

  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [15:0]       wr_data, rd_data;

  logic [CW-1:0]     ptr_inc, ptr_dec;
  logic [7:0]        key;
  logic              key_eq, key_gt, full, walk_end, dump_last;
  logic [31:0]       cnt_ext;
  logic              ins_wr;

  assign ptr_inc   = ptr_r + CW'(1);
  assign ptr_dec   = ptr_r - CW'(1);
  assign key       = rd_data[7:0];
  assign key_eq    = (key == note_r);
  assign key_gt    = (key > note_r);
  assign full      = (cnt_r == CW'(CAPACITY));
  assign walk_end  = (ptr_inc == cnt_r);
  assign dump_last = walk_end || ((32'(ptr_r) + 32'd1) == 32'(shnt_pkg::MAX_OUT));
  assign cnt_ext   = 32'(cnt_r);
  assign ins_wr    = (state_r == shnt_pkg::ST_SHR) && (mode_r == shnt_pkg::MODE_ADD)
                     && (ptr_r == pos_r);

  shnt_ram #(
    .WIDTH (16),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      shnt_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.mode)
            shnt_pkg::MODE_ADD:    state_nxt = (cnt_r == '0) ? shnt_pkg::ST_SHR
                                                             : shnt_pkg::ST_RD;
            shnt_pkg::MODE_REMOVE: state_nxt = (cnt_r == '0) ? shnt_pkg::ST_EMIT
                                                             : shnt_pkg::ST_RD;
            shnt_pkg::MODE_CLEAR:  state_nxt = shnt_pkg::ST_EMIT;
            shnt_pkg::MODE_DUMP:   state_nxt = (cnt_r == '0) ? shnt_pkg::ST_EMIT
                                                             : shnt_pkg::ST_RD;
            default:               state_nxt = shnt_pkg::ST_IDLE;
          endcase
        end
      end
      shnt_pkg::ST_RD: begin
        state_nxt = (mode_r == shnt_pkg::MODE_DUMP) ? shnt_pkg::ST_EMIT : shnt_pkg::ST_CMP;
      end
      shnt_pkg::ST_CMP: begin
        priority if (key_eq) begin
          state_nxt = (mode_r == shnt_pkg::MODE_ADD) ? shnt_pkg::ST_EMIT : shnt_pkg::ST_SHR;
        end else if (mode_r == shnt_pkg::MODE_ADD && (key_gt || walk_end)) begin
          state_nxt = full ? shnt_pkg::ST_EMIT : shnt_pkg::ST_SHR;
        end else if (walk_end) begin
          state_nxt = shnt_pkg::ST_EMIT;
        end else begin
          state_nxt = shnt_pkg::ST_RD;
        end
      end
      shnt_pkg::ST_SHR: begin
        if (mode_r == shnt_pkg::MODE_ADD) begin
          state_nxt = (ptr_r == pos_r) ? shnt_pkg::ST_EMIT : shnt_pkg::ST_SHW;
        end else begin
          state_nxt = (ptr_inc >= cnt_r) ? shnt_pkg::ST_EMIT : shnt_pkg::ST_SHW;
        end
      end
      shnt_pkg::ST_SHW: begin
        state_nxt = shnt_pkg::ST_SHR;
      end
      shnt_pkg::ST_EMIT: begin
        if (res_ready) begin
          state_nxt = (mode_r == shnt_pkg::MODE_DUMP && ent_r && !dump_last)
                      ? shnt_pkg::ST_RD : shnt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = shnt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mode_nxt   = mode_r;
    status_nxt = status_r;
    note_nxt   = note_r;
    vel_nxt    = vel_r;
    ent_nxt    = ent_r;
    ptr_nxt    = ptr_r;
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    cmd_ready  = 1'b0;
    res_valid  = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = ptr_r[AW-1:0];
    wr_data    = rd_data;
    rd_en      = 1'b0;
    rd_addr    = ptr_r[AW-1:0];
    unique case (state_r)
      shnt_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          mode_nxt   = cmd.mode;
          note_nxt   = cmd.note;
          vel_nxt    = cmd.velocity;
          ptr_nxt    = '0;
          pos_nxt    = '0;
          ent_nxt    = 1'b0;
          status_nxt = shnt_pkg::STAT_DONE;
          unique case (cmd.mode)
            shnt_pkg::MODE_REMOVE: begin
              if (cnt_r == '0) status_nxt = shnt_pkg::STAT_ABSENT;
            end
            shnt_pkg::MODE_CLEAR: cnt_nxt = '0;
            shnt_pkg::MODE_DUMP:  ent_nxt = (cnt_r != '0);
            default: ;
          endcase
        end
      end
      shnt_pkg::ST_RD: begin
        rd_en = 1'b1;
      end
      shnt_pkg::ST_CMP: begin
        priority if (key_eq) begin
          if (mode_r == shnt_pkg::MODE_ADD) status_nxt = shnt_pkg::STAT_HELD;
        end else if (mode_r == shnt_pkg::MODE_ADD && (key_gt || walk_end)) begin
          if (full) begin
            status_nxt = shnt_pkg::STAT_FULL;
          end else begin
            pos_nxt = key_gt ? ptr_r : ptr_inc;
            ptr_nxt = cnt_r;
          end
        end else if (walk_end) begin
          status_nxt = shnt_pkg::STAT_ABSENT;
        end else begin
          ptr_nxt = ptr_inc;
        end
      end
      shnt_pkg::ST_SHR: begin
        if (mode_r == shnt_pkg::MODE_ADD) begin
          if (ptr_r == pos_r) begin
            wr_en   = 1'b1;
            wr_data = {vel_r, note_r};
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            rd_en   = 1'b1;
            rd_addr = ptr_dec[AW-1:0];
          end
        end else begin
          if (ptr_inc >= cnt_r) begin
            cnt_nxt = cnt_r - CW'(1);
          end else begin
            rd_en   = 1'b1;
            rd_addr = ptr_inc[AW-1:0];
          end
        end
      end
      shnt_pkg::ST_SHW: begin
        wr_en   = 1'b1;
        ptr_nxt = (mode_r == shnt_pkg::MODE_ADD) ? ptr_dec : ptr_inc;
      end
      shnt_pkg::ST_EMIT: begin
        res_valid = 1'b1;
        if (res_ready && ent_r && !dump_last) ptr_nxt = ptr_inc;
      end
      default: ;
    endcase
  end

  always_comb begin
    res.note        = ent_r ? rd_data[7:0] : 8'd0;
    res.velocity    = ent_r ? rd_data[15:8] : 8'd0;
    res.entry_valid = ent_r;
    res.status      = status_r;
    res.last        = ent_r ? dump_last : 1'b1;
    res.held_count  = cnt_ext[4:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= shnt_pkg::ST_IDLE;
      cnt_r   <= '0;
      ent_r   <= 1'b0;
      ptr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ent_r   <= ent_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    status_r <= status_nxt;
    note_r   <= note_nxt;
    vel_r    <= vel_nxt;
    pos_r    <= pos_nxt;
  end

`include "sorted_held_note_table_assert.svh"

  `SHNT_ASSERT(a_cnt_bound, 1'b1, cnt_r <= CW'(CAPACITY), "entry count above capacity")
  `SHNT_ASSERT(a_rd_in_range, state_r == shnt_pkg::ST_RD, ptr_r < cnt_r, "walk read past count")
  `SHNT_ASSERT_NEXT(a_insert_count, ins_wr, cnt_r == CW'($past(cnt_r) + 1'b1), "count not bumped")

endmodule

[design/sorted_held_note_table.sv]
// Top level of the sorted held-note table: stream ports and result register.
//
//   channel  dir  tdata (low bit up)                        tuser        tlast
//   in_      in   note[7:0] velocity[15:8]                  mode[1:0]    -
//   out_     out  note[7:0] velocity[15:8] status[17:16]    entry_valid  last
//                 held_count[22:18] pad[23]
//
// Add/remove: read and compare steps per entry walked by the search, then read and
// write steps per entry shifted. Clear emits at once. Dump reads and emits each entry.
// All walking goes through the single read port of the entry store.
// Reset (rst_n low, synchronous) empties the table at once; no clearing pass.
// A stalled out_ beat holds the sequencer at its emit step; in_tready is low while busy.
module sorted_held_note_table #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // note[7:0], velocity[15:8]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // note, velocity, status, held_count, pad
  output logic        out_tuser,  // entry_valid
  output logic        out_tlast
);

  shnt_pkg::cmd_t    cmd;
  shnt_pkg::result_t res, out_data_r;
  logic              res_valid, res_ready;
  logic              out_valid_r;

  assign cmd.mode     = shnt_pkg::mode_t'(in_tuser);
  assign cmd.note     = in_tdata[7:0];
  assign cmd.velocity = in_tdata[15:8];

  assign res_ready = !out_valid_r || out_tready;

  shnt_core #(
    .CAPACITY (CAPACITY)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_tvalid),
    .cmd_ready (in_tready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r.held_count, out_data_r.status,
                       out_data_r.velocity, out_data_r.note};
  assign out_tuser  = out_data_r.entry_valid;
  assign out_tlast  = out_data_r.last;

`include "sorted_held_note_table_assert.svh"

  `SHNT_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "second beat taken while busy")
  `SHNT_ASSERT_NEXT(a_load_when_free, res_valid && !res_ready, out_valid_r, "result dropped on full register")

endmodule

[tb/sorted_held_note_table_tb.sv]
// Self-checking testbench for the sorted held-note table: directed and random note streams.
module sorted_held_note_table_tb;

  localparam int HELD_CAPACITY = 16;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 100;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  logic [7:0]        held_note [HELD_CAPACITY];
  logic [7:0]        held_vel  [HELD_CAPACITY];
  int                held_total = 0;
  shnt_pkg::result_t owed_results [$];

  int mismatches     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  int pool_base      = 0;

  sorted_held_note_table #(.CAPACITY(HELD_CAPACITY)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void owe(logic [7:0] n, logic [7:0] v, logic ev,
                              shnt_pkg::status_t st, logic l);
    shnt_pkg::result_t r;
    r.note        = n;
    r.velocity    = v;
    r.entry_valid = ev;
    r.status      = st;
    r.last        = l;
    r.held_count  = held_total[4:0];
    owed_results.push_back(r);
  endfunction

  function automatic void apply_note_op(shnt_pkg::mode_t m, logic [7:0] n, logic [7:0] v);
    int                pos;
    int                i;
    int                span;
    shnt_pkg::status_t st;
    pos = 0;
    st  = shnt_pkg::STAT_DONE;
    case (m)
      shnt_pkg::MODE_ADD: begin
        while (pos < held_total && held_note[pos] < n) pos++;
        if (pos < held_total && held_note[pos] == n) begin
          st = shnt_pkg::STAT_HELD;
        end else if (held_total >= HELD_CAPACITY) begin
          st = shnt_pkg::STAT_FULL;
        end else begin
          for (i = held_total; i > pos; i--) begin
            held_note[i] = held_note[i-1];
            held_vel[i]  = held_vel[i-1];
          end
          held_note[pos] = n;
          held_vel[pos]  = v;
          held_total++;
        end
        owe(8'd0, 8'd0, 1'b0, st, 1'b1);
      end
      shnt_pkg::MODE_REMOVE: begin
        while (pos < held_total && held_note[pos] != n) pos++;
        if (pos >= held_total) begin
          st = shnt_pkg::STAT_ABSENT;
        end else begin
          for (i = pos; i + 1 < held_total; i++) begin
            held_note[i] = held_note[i+1];
            held_vel[i]  = held_vel[i+1];
          end
          held_total--;
        end
        owe(8'd0, 8'd0, 1'b0, st, 1'b1);
      end
      shnt_pkg::MODE_CLEAR: begin
        held_total = 0;
        owe(8'd0, 8'd0, 1'b0, shnt_pkg::STAT_DONE, 1'b1);
      end
      default: begin
        if (held_total == 0) begin
          owe(8'd0, 8'd0, 1'b0, shnt_pkg::STAT_DONE, 1'b1);
        end else begin
          span = (held_total < shnt_pkg::MAX_OUT) ? held_total : shnt_pkg::MAX_OUT;
          for (i = 0; i < span; i++)
            owe(held_note[i], held_vel[i], 1'b1, shnt_pkg::STAT_DONE, i + 1 == span);
        end
      end
    endcase
  endfunction

  // valid stays high across back-to-back beats; it only drops when a gap is taken or when wait_all_results runs
  task automatic send_beat(shnt_pkg::mode_t m, logic [7:0] n, logic [7:0] v);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= {v, n};
    do @(posedge clk); while (!in_tready);
    apply_note_op(m, n, v);
  endtask

  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_note(bit favor_held);
    int r;
    r = $urandom_range(0, 99);
    if (held_total > 0 && r < (favor_held ? 60 : 20))
      return held_note[$urandom_range(0, held_total - 1)];
    if (r < 80)
      return 8'(pool_base + $urandom_range(0, 23));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_empty_and_edges();
    send_beat(shnt_pkg::MODE_DUMP,   8'h00, 8'h00);
    send_beat(shnt_pkg::MODE_REMOVE, 8'h2A, 8'hFF);
    send_beat(shnt_pkg::MODE_ADD,    8'hFF, 8'hFF);
    send_beat(shnt_pkg::MODE_ADD,    8'h00, 8'h00);
    send_beat(shnt_pkg::MODE_ADD,    8'h00, 8'hAA);
    send_beat(shnt_pkg::MODE_DUMP,   8'hFF, 8'hFF);
    send_beat(shnt_pkg::MODE_REMOVE, 8'hFF, 8'h00);
    send_beat(shnt_pkg::MODE_CLEAR,  8'h55, 8'h55);
    wait_all_results();
  endtask

  // descending adds insert at the head every time: longest shifts
  task automatic test_full_table();
    for (int k = 0; k < HELD_CAPACITY; k++)
      send_beat(shnt_pkg::MODE_ADD, 8'((HELD_CAPACITY - 1 - k) * 17),
                ~8'((HELD_CAPACITY - 1 - k) * 17));
    send_beat(shnt_pkg::MODE_ADD,    8'h81, 8'h7E);
    send_beat(shnt_pkg::MODE_ADD,    8'hEE, 8'h01);
    send_beat(shnt_pkg::MODE_DUMP,   8'h00, 8'h00);
    send_beat(shnt_pkg::MODE_REMOVE, 8'h00, 8'h00);
    wait_all_results();
  endtask

  task automatic test_random_notes(int idle_pct, int stall_pct, int beats);
    int              r;
    shnt_pkg::mode_t m;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    pool_base      = $urandom_range(0, 232);
    for (int k = 0; k < beats; k++) begin
      r = $urandom_range(0, 99);
      if (r < 50)      m = shnt_pkg::MODE_ADD;
      else if (r < 78) m = shnt_pkg::MODE_REMOVE;
      else if (r < 95) m = shnt_pkg::MODE_DUMP;
      else             m = shnt_pkg::MODE_CLEAR;
      send_beat(m, pick_note(m == shnt_pkg::MODE_REMOVE), 8'($urandom_range(0, 255)));
    end
    wait_all_results();
  endtask

  task automatic log_mismatch(string why, shnt_pkg::result_t want, shnt_pkg::result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%s: exp note=%0d vel=%0d valid=%0b st=%0d last=%0b cnt=%0d",
                " | got note=%0d vel=%0d valid=%0b st=%0d last=%0b cnt=%0d"},
               why, want.note, want.velocity, want.entry_valid, want.status, want.last,
               want.held_count, got.note, got.velocity, got.entry_valid, got.status,
               got.last, got.held_count);
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    shnt_pkg::result_t got;
    shnt_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.note        = out_tdata[7:0];
      got.velocity    = out_tdata[15:8];
      got.status      = shnt_pkg::status_t'(out_tdata[17:16]);
      got.held_count  = out_tdata[22:18];
      got.entry_valid = out_tuser;
      got.last        = out_tlast;
      if (owed_results.size() == 0) begin
        log_mismatch("unexpected beat", '0, got);
      end else begin
        want = owed_results.pop_front();
        if (got.note !== want.note || got.velocity !== want.velocity ||
            got.entry_valid !== want.entry_valid || got.status !== want.status ||
            got.last !== want.last || got.held_count !== want.held_count)
          log_mismatch("mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_and_edges();
    test_full_table();
    test_random_notes(0, 0, 106);
    test_random_notes(55, 0, 106);
    test_random_notes(0, 55, 106);
    test_random_notes(14, 14, 106);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (owed_results.size() != 0) mismatches++;
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
